### rtl/linear_blend_vertex_skinning_assert.svh
// assertion macros for the skinning block
`ifndef LINEAR_BLEND_VERTEX_SKINNING_ASSERT_SVH
`define LINEAR_BLEND_VERTEX_SKINNING_ASSERT_SVH

// implication checked on every edge outside reset
`define LBS_ASSERT_IMP(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");

// next-cycle implication checked outside reset
`define LBS_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");

`endif

### rtl/lbs_pkg.sv
`default_nettype none
package lbs_pkg;
   localparam int MaxBones   = 64;
   localparam int FracBits   = 16;
   localparam int WeightFrac = 15;
   localparam int BoneWords  = 12;
   localparam int BoneIdxW   = 6;
   localparam int RowWords   = 4;
   localparam int Lanes      = 4;
   localparam int TW         = 46;
   localparam int AccW       = 64;
   localparam int Latency    = 4;

   typedef enum logic {
      OP_WRITE = 1'b0,
      OP_SKIN  = 1'b1
   } op_type;

   typedef logic signed [31:0] word_type;
   typedef word_type row_type [RowWords];
   typedef logic signed [TW-1:0] t_type;

   // three sums of one lane, one per row
   typedef struct packed {
      logic signed [AccW-1:0] x;
      logic signed [AccW-1:0] y;
      logic signed [AccW-1:0] z;
   } lane_sum_type;

   function automatic logic signed [TW-1:0] sat_t(input logic signed [65:0] v);
      if (v > 66'sd35184372088831) return {1'b0, {(TW-1){1'b1}}};
      if (v < -66'sd35184372088832) return {1'b1, {(TW-1){1'b0}}};
      return v[TW-1:0];
   endfunction
endpackage
`default_nettype wire

### rtl/linear_blend_vertex_skinning.sv
// channel   | ports                                  | handshake
// request   | req_opcode, req_pos_*, req_influence_*, req_entry_* | start & !busy
// response  | rsp_skinned_x/y/z                      | rsp_valid, one cycle
//
// one transaction per cycle; busy is always low
// a skin transaction's result reaches the rsp ports through the read, product, row sum
// and weight registers in the lanes, then the merge register
// writes give no result; they are registered into the palette memories
// reset clears only the valid pipe; palette contents are undefined until written
// the receiver cannot stall
`default_nettype none
`include "linear_blend_vertex_skinning_assert.svh"
module linear_blend_vertex_skinning (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic               req_opcode,
   input  wire logic signed [31:0] req_pos_x,
   input  wire logic signed [31:0] req_pos_y,
   input  wire logic signed [31:0] req_pos_z,
   input  wire logic [23:0]        req_influence_bones,
   input  wire logic [63:0]        req_influence_weights,
   input  wire logic [5:0]         req_entry_bone,
   input  wire logic [3:0]         req_entry_slot,
   input  wire logic signed [31:0] req_entry_value,
   output logic                    rsp_valid,
   output logic signed [31:0]      rsp_skinned_x,
   output logic signed [31:0]      rsp_skinned_y,
   output logic signed [31:0]      rsp_skinned_z
);
   import lbs_pkg::*;

   logic take;
   logic wr_en;
   logic [Latency:0] vld_ff, vld_in;
   lane_sum_type lane_sum [Lanes];

   assign busy  = 1'b0;
   assign take  = start && !busy;
   assign wr_en = take && (req_opcode == OP_WRITE) && (req_entry_slot < 4'(BoneWords));

   genvar k;
   generate
      for (k = 0; k < Lanes; k++) begin : g_lane
         lbs_lane u_lane (
            .clock    (clock),
            .wr_en    (wr_en),
            .wr_bone  (req_entry_bone),
            .wr_slot  (req_entry_slot),
            .wr_value (req_entry_value),
            .rd_bone  (req_influence_bones[k*BoneIdxW +: BoneIdxW]),
            .weight   (req_influence_weights[k*16 +: 16]),
            .px       (req_pos_x),
            .py       (req_pos_y),
            .pz       (req_pos_z),
            .sum      (lane_sum[k])
         );
      end
   endgenerate

   lbs_merge u_merge (
      .clock    (clock),
      .lane_sum (lane_sum),
      .out_x    (rsp_skinned_x),
      .out_y    (rsp_skinned_y),
      .out_z    (rsp_skinned_z)
   );

   assign vld_in = {vld_ff[Latency-1:0], take && (req_opcode == OP_SKIN)};

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else       vld_ff <= vld_in;
   end

   assign rsp_valid = vld_ff[Latency];

   `LBS_ASSERT_NEXT(a_skin_tracked, clock, reset, take && req_opcode == OP_SKIN, vld_ff[0])
   `LBS_ASSERT_NEXT(a_write_silent, clock, reset, !(take && req_opcode == OP_SKIN), !vld_ff[0])
   `LBS_ASSERT_IMP(a_never_busy, clock, reset, 1'b1, !busy)
endmodule
`default_nettype wire

### rtl/lbs_lane.sv
`default_nettype none
// one influence: twelve element memories, row transform, weight multiply
module lbs_lane (
   input  wire logic                           clock,
   input  wire logic                           wr_en,
   input  wire logic [lbs_pkg::BoneIdxW-1:0]   wr_bone,
   input  wire logic [3:0]                     wr_slot,
   input  wire logic [31:0]                    wr_value,
   input  wire logic [lbs_pkg::BoneIdxW-1:0]   rd_bone,
   input  wire logic [15:0]                    weight,
   input  wire logic signed [31:0]             px,
   input  wire logic signed [31:0]             py,
   input  wire logic signed [31:0]             pz,
   output lbs_pkg::lane_sum_type               sum
);
   import lbs_pkg::*;

   // one memory per matrix element: 12 x 64 words
   logic [31:0] mem_ff [BoneWords][MaxBones];
   logic [31:0] rd_ff [BoneWords];
   logic signed [31:0] p_ff [3];
   logic [15:0] w1_ff, w2_ff, w3_ff;
   logic signed [63:0] prod_ff [3][3];
   logic signed [31:0] off_ff [3];
   t_type t_ff [3];
   logic signed [AccW-1:0] s_ff [3];

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_slot][wr_bone] <= wr_value;
   end

   genvar g;
   generate
      for (g = 0; g < BoneWords; g++) begin : g_rd
         always_ff @(posedge clock) rd_ff[g] <= mem_ff[g][rd_bone];
      end
   endgenerate

   always_ff @(posedge clock) begin
      p_ff[0] <= px;
      p_ff[1] <= py;
      p_ff[2] <= pz;
      w1_ff <= weight;
      w2_ff <= w1_ff;
      w3_ff <= w2_ff;
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++)
            prod_ff[r][c] <= $signed(rd_ff[r*RowWords+c]) * p_ff[c];
         off_ff[r] <= $signed(rd_ff[r*RowWords+3]);
      end
      for (int r = 0; r < 3; r++) begin
         t_ff[r] <= sat_t(66'(prod_ff[r][0] >>> FracBits) + 66'(prod_ff[r][1] >>> FracBits)
                    + 66'(prod_ff[r][2] >>> FracBits) + 66'(off_ff[r]));
         s_ff[r] <= AccW'(t_ff[r]) * $signed({{(AccW-16){1'b0}}, w3_ff});
      end
   end

   assign sum.x = s_ff[0];
   assign sum.y = s_ff[1];
   assign sum.z = s_ff[2];
endmodule
`default_nettype wire

### rtl/lbs_merge.sv
`default_nettype none
// adds the four lane sums, shifts out the weight fraction and saturates
module lbs_merge (
   input  wire logic                    clock,
   input  lbs_pkg::lane_sum_type        lane_sum [lbs_pkg::Lanes],
   output logic signed [31:0]           out_x,
   output logic signed [31:0]           out_y,
   output logic signed [31:0]           out_z
);
   import lbs_pkg::*;

   function automatic logic signed [31:0] fin(input logic signed [AccW-1:0] a);
      logic signed [AccW-1:0] s;
      s = a >>> WeightFrac;
      if (s > 64'sd2147483647) return 32'h7fffffff;
      if (s < -64'sd2147483648) return 32'h80000000;
      return s[31:0];
   endfunction

   logic signed [AccW-1:0] ax_in, ay_in, az_in;

   always_comb begin
      ax_in = '0; ay_in = '0; az_in = '0;
      for (int k = 0; k < Lanes; k++) begin
         ax_in = ax_in + lane_sum[k].x;
         ay_in = ay_in + lane_sum[k].y;
         az_in = az_in + lane_sum[k].z;
      end
   end

   always_ff @(posedge clock) begin
      out_x <= fin(ax_in);
      out_y <= fin(ay_in);
      out_z <= fin(az_in);
   end
endmodule
`default_nettype wire

### tb/sv/skin_checker.sv
`default_nettype none
module skin_checker
   import lbs_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic               busy,
   input  wire logic               req_opcode,
   input  wire logic signed [31:0] req_pos_x,
   input  wire logic signed [31:0] req_pos_y,
   input  wire logic signed [31:0] req_pos_z,
   input  wire logic [23:0]        req_influence_bones,
   input  wire logic [63:0]        req_influence_weights,
   input  wire logic [5:0]         req_entry_bone,
   input  wire logic [3:0]         req_entry_slot,
   input  wire logic signed [31:0] req_entry_value,
   input  wire logic               rsp_valid,
   input  wire logic signed [31:0] rsp_skinned_x,
   input  wire logic signed [31:0] rsp_skinned_y,
   input  wire logic signed [31:0] rsp_skinned_z,
   output int                      errors,
   output int                      pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      word_type x;
      word_type y;
      word_type z;
   } position_type;

   localparam longint TMax = 64'sd35184372088831;
   localparam longint TMin = -64'sd35184372088832;

   word_type     palette [MaxBones*BoneWords];
   position_type expected_positions [$];

   initial errors = 0;
   assign pending = expected_positions.size();

   function automatic longint clamp(longint v, longint lo, longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   // one row of one bone matrix applied to (x, y, z, 1), saturated to 46 bits
   function automatic longint row_eval(int bone, int row, longint p [3]);
      longint t;
      t = longint'(palette[bone*BoneWords + row*RowWords + 3]);
      for (int c = 0; c < 3; c++)
         t += (longint'(palette[bone*BoneWords + row*RowWords + c]) * p[c]) >>> FracBits;
      return clamp(t, TMin, TMax);
   endfunction

   function automatic position_type blend_position(word_type px, word_type py, word_type pz,
                                                   logic [23:0] bones, logic [63:0] weights);
      longint       p [3];
      longint       acc [3];
      longint       w;
      int           bone;
      longint       v [3];
      position_type r;
      p[0] = longint'(px);
      p[1] = longint'(py);
      p[2] = longint'(pz);
      acc = '{0, 0, 0};
      for (int k = 0; k < Lanes; k++) begin
         bone = int'(bones[BoneIdxW*k +: BoneIdxW]);
         w    = longint'({48'd0, weights[16*k +: 16]});
         if (bone < MaxBones)
            for (int row = 0; row < 3; row++) acc[row] += w * row_eval(bone, row, p);
      end
      for (int row = 0; row < 3; row++)
         v[row] = clamp(acc[row] >>> WeightFrac, -64'sd2147483648, 64'sd2147483647);
      r.x = word_type'(v[0]);
      r.y = word_type'(v[1]);
      r.z = word_type'(v[2]);
      return r;
   endfunction

   always @(posedge clock) begin
      position_type got;
      position_type want;
      if (!reset && start && !busy) begin
         if (op_type'(req_opcode) == OP_SKIN)
            expected_positions.push_back(blend_position(req_pos_x, req_pos_y, req_pos_z,
                                          req_influence_bones, req_influence_weights));
         else if (int'(req_entry_bone) < MaxBones && int'(req_entry_slot) < BoneWords)
            palette[int'(req_entry_bone)*BoneWords + int'(req_entry_slot)] = req_entry_value;
      end
      if (!reset && rsp_valid) begin
         got.x = rsp_skinned_x;
         got.y = rsp_skinned_y;
         got.z = rsp_skinned_z;
         if (expected_positions.size() == 0) begin
            $error("unexpected result transaction x=%0d y=%0d z=%0d", got.x, got.y, got.z);
            errors++;
         end else begin
            want = expected_positions.pop_front();
            if (got.x !== want.x) begin
               $error("skinned_x expected %0d actual %0d", want.x, got.x);
               errors++;
            end
            if (got.y !== want.y) begin
               $error("skinned_y expected %0d actual %0d", want.y, got.y);
               errors++;
            end
            if (got.z !== want.z) begin
               $error("skinned_z expected %0d actual %0d", want.z, got.z);
               errors++;
            end
         end
      end
   end
endmodule
`default_nettype wire

### tb/sv/testbench.sv
`default_nettype none
module testbench;
   import lbs_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ItemTarget = 1900;
   localparam int StallLimit = 400;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic               req_opcode = 1'b0;
   logic signed [31:0] req_pos_x = '0;
   logic signed [31:0] req_pos_y = '0;
   logic signed [31:0] req_pos_z = '0;
   logic [23:0]        req_influence_bones = '0;
   logic [63:0]        req_influence_weights = '0;
   logic [5:0]         req_entry_bone = '0;
   logic [3:0]         req_entry_slot = '0;
   logic signed [31:0] req_entry_value = '0;
   logic               rsp_valid;
   logic signed [31:0] rsp_skinned_x;
   logic signed [31:0] rsp_skinned_y;
   logic signed [31:0] rsp_skinned_z;
   int                 errors;
   int                 pending;

   // slots written so far per bone; skins only use fully written bones
   logic [BoneWords-1:0] written [MaxBones];
   int                   item_count = 0;
   int                   skin_count = 0;
   int                   write_count = 0;
   int                   idle_count = 0;
   bit                   idling_on = 1'b1;
   bit                   drained = 1'b0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   linear_blend_vertex_skinning dut (.*);

   skin_checker checker_inst (.*);

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) idle_count <= 0;
      else idle_count <= idle_count + 1;
      if (idle_count >= StallLimit) begin
         $display("tb: failure");
         $finish;
      end
   end

   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 5))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'h0001_0000;
         3: return 32'($signed($urandom_range(0, 32'h3FFFF)) - 32'sh1FFFF);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [15:0] pick_weight();
      case ($urandom_range(0, 4))
         0: return 16'hFFFF;
         1: return 16'h0000;
         2: return 16'h2000;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic int pick_ready_bone();
      int tries;
      int b;
      for (tries = 0; tries < 200; tries++) begin
         b = $urandom_range(0, MaxBones-1);
         if (&written[b]) return b;
      end
      for (b = 0; b < MaxBones; b++) if (&written[b]) return b;
      return 0;
   endfunction

   task automatic gap();
      int n;
      if (idling_on && $urandom_range(0, 5) == 0) begin
         n = $urandom_range(1, 8);
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic issue(op_type op, logic [31:0] x, logic [31:0] y, logic [31:0] z,
                        logic [23:0] bones, logic [63:0] weights,
                        logic [5:0] bone, logic [3:0] slot, logic [31:0] value);
      gap();
      start                 <= 1'b1;
      req_opcode            <= op;
      req_pos_x             <= x;
      req_pos_y             <= y;
      req_pos_z             <= z;
      req_influence_bones   <= bones;
      req_influence_weights <= weights;
      req_entry_bone        <= bone;
      req_entry_slot        <= slot;
      req_entry_value       <= value;
      @(posedge clock);
      while (busy) @(posedge clock);
      item_count++;
      if (op == OP_SKIN) skin_count++;
      else begin
         write_count++;
         if (int'(slot) < BoneWords) written[bone][slot] = 1'b1;
      end
   endtask

   task automatic write_entry(int bone, int slot, logic [31:0] value);
      issue(OP_WRITE, $urandom, $urandom, $urandom, 24'($urandom), {$urandom, $urandom},
            6'(bone), 4'(slot), value);
   endtask

   task automatic skin_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                              logic [23:0] bones, logic [63:0] weights);
      issue(OP_SKIN, x, y, z, bones, weights, 6'($urandom), 4'($urandom), $urandom);
   endtask

   task automatic random_skin();
      logic [23:0] bones;
      logic [63:0] weights;
      for (int k = 0; k < Lanes; k++) begin
         bones[BoneIdxW*k +: BoneIdxW] = 6'(pick_ready_bone());
         weights[16*k +: 16] = pick_weight();
      end
      // weights that sum to exactly one
      if ($urandom_range(0, 3) == 0) begin
         weights[15:0]  = 16'($urandom_range(0, 16'h8000));
         weights[31:16] = 16'($urandom_range(0, 16'h8000 - weights[15:0]));
         weights[47:32] = 16'($urandom_range(0, 16'h8000 - weights[15:0] - weights[31:16]));
         weights[63:48] = 16'h8000 - weights[15:0] - weights[31:16] - weights[47:32];
      end
      skin_vertex(pick_word(), pick_word(), pick_word(), bones, weights);
   endtask

   initial begin
      int b;
      for (int i = 0; i < MaxBones; i++) written[i] = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: bone 0 at the positive extreme, bone 63 at the negative one
      for (int s = 0; s < BoneWords; s++) write_entry(0, s, 32'h7FFF_FFFF);
      for (int s = 0; s < BoneWords; s++) write_entry(63, s, 32'h8000_0000);
      // slots past the matrix are dropped
      write_entry(0, 15, 32'h0000_0000);
      skin_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 24'h000000, 64'hFFFF_FFFF_FFFF_FFFF);
      skin_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 24'hFFFFFF, 64'hFFFF_FFFF_FFFF_FFFF);
      skin_vertex(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 24'hFC0FC0, 64'h0000_0000_0000_0000);
      skin_vertex(32'h0001_0000, 32'hFFFF_0000, 32'h0000_0001, 24'h03F03F, 64'h0001_8000_0000_FFFF);

      while (item_count < ItemTarget) begin
         if (item_count > ItemTarget - 200) idling_on = 1'b0;
         // hold off once until the pipe has drained
         if (!drained && item_count >= ItemTarget / 2) begin
            drained = 1'b1;
            start <= 1'b0;
            while (pending != 0) @(posedge clock);
         end
         case ($urandom_range(0, 9))
            0, 1: begin
               b = $urandom_range(0, MaxBones-1);
               for (int s = 0; s < BoneWords; s++) write_entry(b, s, pick_word());
            end
            2: write_entry($urandom_range(0, MaxBones-1), $urandom_range(0, 15), pick_word());
            default: random_skin();
         endcase
      end
      start <= 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (Latency + 5) @(posedge clock);
      $display("covered %0d transactions: %0d vertex skins, %0d palette writes",
               item_count, skin_count, write_count);
      if (errors == 0 && pending == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end
endmodule
`default_nettype wire
